// File: design/msb_pkg.sv
// ----------------------------------------------------------------------------
// msb_pkg - shared definitions for the multi-slot timer bank
// Field widths, default sizes, action and reply codes, slot modes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package msb_pkg;

	localparam int NUM_SLOTS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 32;
	localparam int SLOT_W         = 4;
	localparam int IN_CNT_W       = 32;
	localparam int MAX_FIRE       = 16;
	localparam int FIRE_CNT_W     = 5;

	typedef enum logic [1:0] {
		MODE_DONE   = 2'd0,
		MODE_ACTIVE = 2'd1,
		MODE_READY  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_CREATE  = 2'd0,
		ACT_TICK    = 2'd1,
		ACT_QUERY   = 2'd2,
		ACT_SERVICE = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		KIND_CREATE  = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_STATE   = 2'd2,
		KIND_SERVICE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_REPLY,
		ST_FLUSH
	} state_t;

endpackage

// File: design/multi_slot_timer_bank.sv
// ----------------------------------------------------------------------------
// multi_slot_timer_bank - bank of periodic and one-shot timer slots
// Create, tick, query and service actions on a bank of timer slots; service
// emits one fire event per ready slot, at most MAX_FIRE, walked in slot order.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | action slot rewrite load_count
//          |                      | reload_period start_mode
//  out     | out_valid / out_stall| reply_kind reply_slot slot_mode fired last
//
// Steps: create and query are accepted, then replied to. Tick and service
// are accepted, then sweep every slot through the single read port of the
// count store and the shared decrement unit, and end in one reply or flush
// step.
// Reset clears the registered flags and modes at once; counts and periods are
// only read for registered slots, so the store needs no clearing pass.
// A stalled output holds the reply; during service the sweep holds on a
// fire event while the output register is still occupied.
// ----------------------------------------------------------------------------
module multi_slot_timer_bank
	import msb_pkg::*;
#(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [SLOT_W-1:0]   slot,
	input  logic                rewrite,
	input  logic [IN_CNT_W-1:0] load_count,
	input  logic [IN_CNT_W-1:0] reload_period,
	input  logic [1:0]          start_mode,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          reply_kind,
	output logic [SLOT_W-1:0]   reply_slot,
	output logic [1:0]          slot_mode,
	output logic                fired,
	output logic                last
);

	localparam int AW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IDX_W = $clog2(NUM_SLOTS + 1);
	localparam int DW    = 2 * COUNT_BITS;

	// sequencer
	state_t state_q, state_d;

	// latched item
	act_t                  act_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  rewrite_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] per_q;
	mode_t                 smode_q;

	// per-slot flags, cleared by reset
	logic  reg_q  [NUM_SLOTS];
	mode_t mode_q [NUM_SLOTS];

	// sweep pipeline: read address counter and slot being processed
	logic [IDX_W-1:0] idx_q;
	logic             p_vld_s1;
	logic [AW-1:0]    p_idx_s1;

	// held fire event, so the final one can carry last
	logic                  held_vld_q;
	logic [SLOT_W-1:0]     held_slot_q;
	mode_t                 held_mode_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;

	// output register
	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [SLOT_W-1:0] out_slot_q;
	mode_t             out_mode_q;
	logic              out_fired_q;
	logic              out_last_q;

	// store and shared unit
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_wa;
	logic [DW-1:0]         ram_wd, ram_rd;
	logic [COUNT_BITS-1:0] rd_rem, rd_per, alu_in, alu_dec;
	logic                  alu_zero;

	// combinational controls
	logic              accept, out_free, advance;
	logic              emit, emit_fired, emit_last;
	kind_t             emit_kind;
	logic [SLOT_W-1:0] emit_slot;
	mode_t             emit_mode;
	logic              mode_we, reg_set;
	logic [AW-1:0]     mode_wa;
	mode_t             mode_wd;
	logic              fire_rec;
	mode_t             fire_mode;

	// reply lookup helpers
	logic          c_in_range, c_reg, c_load;
	logic [AW-1:0] c_addr;
	mode_t         c_mode;
	mode_t         p_mode;
	logic          p_reg, tick_hit, svc_hit, fire_ok;

	msb_count_ram #(
		.DEPTH(NUM_SLOTS),
		.DW   (DW)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_wa),
		.wr_data(ram_wd),
		.rd_en  (ram_re),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(ram_rd)
	);

	msb_dec_unit #(
		.WIDTH(COUNT_BITS)
	) u_dec (
		.operand(alu_in),
		.is_zero(alu_zero),
		.dec    (alu_dec)
	);

	assign rd_rem   = ram_rd[COUNT_BITS-1:0];
	assign rd_per   = ram_rd[DW-1:COUNT_BITS];
	// tick tests the count, service tests the period
	assign alu_in   = (act_q == ACT_TICK) ? rd_rem : rd_per;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// slot addressed by create or query
	assign c_in_range = (32'(slot_q) < NUM_SLOTS);
	assign c_addr     = AW'(slot_q);
	assign c_reg      = c_in_range && reg_q[c_addr];
	assign c_mode     = mode_q[c_addr];
	assign c_load     = c_in_range && (!c_reg || c_mode == MODE_DONE ||
		(c_mode == MODE_ACTIVE && rewrite_q));

	// slot under the sweep
	assign p_reg    = reg_q[p_idx_s1];
	assign p_mode   = mode_q[p_idx_s1];
	assign tick_hit = p_vld_s1 && p_reg && p_mode == MODE_ACTIVE && act_q == ACT_TICK;
	assign svc_hit  = p_vld_s1 && p_reg && p_mode == MODE_READY && act_q == ACT_SERVICE;
	assign fire_ok  = svc_hit && (fire_cnt_q < FIRE_CNT_W'(MAX_FIRE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		advance    = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_wa     = p_idx_s1;
		ram_wd     = {rd_per, alu_dec};
		mode_we    = 1'b0;
		mode_wa    = p_idx_s1;
		mode_wd    = MODE_DONE;
		reg_set    = 1'b0;
		fire_rec   = 1'b0;
		fire_mode  = alu_zero ? MODE_DONE : MODE_ACTIVE;
		emit       = 1'b0;
		emit_kind  = KIND_SERVICE;
		emit_slot  = held_slot_q;
		emit_mode  = held_mode_q;
		emit_fired = 1'b1;
		emit_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (action == ACT_TICK || action == ACT_SERVICE) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_REPLY;
					end
				end
			end
			ST_SWEEP: begin
				// hold when a new fire event must push the held one out
				advance = !(fire_ok && held_vld_q && !out_free);
				if (advance) begin
					ram_re = (idx_q != IDX_W'(NUM_SLOTS));
					if (tick_hit) begin
						if (alu_zero) begin
							mode_we = 1'b1;
							mode_wd = MODE_READY;
						end else begin
							ram_we = 1'b1;
						end
					end
					if (svc_hit) begin
						mode_we = 1'b1;
						mode_wd = fire_mode;
						ram_we  = !alu_zero;
						fire_rec = fire_ok;
						emit     = fire_ok && held_vld_q;
					end
					if (idx_q == IDX_W'(NUM_SLOTS) && !p_vld_s1) begin
						state_d = (act_q == ACT_TICK) ? ST_REPLY : ST_FLUSH;
					end
				end
			end
			ST_REPLY: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_fired = 1'b0;
					emit_last  = 1'b1;
					emit_slot  = slot_q;
					state_d    = ST_IDLE;
					case (act_q)
						ACT_CREATE: begin
							emit_kind = KIND_CREATE;
							if (c_load) begin
								ram_we  = 1'b1;
								ram_wa  = c_addr;
								ram_wd  = {per_q, cnt_q};
								mode_we = 1'b1;
								mode_wa = c_addr;
								mode_wd = smode_q;
								reg_set = 1'b1;
								emit_mode = smode_q;
							end else begin
								emit_mode = c_reg ? c_mode : MODE_NONE;
							end
						end
						ACT_QUERY: begin
							emit_kind = KIND_STATE;
							emit_mode = c_reg ? c_mode : MODE_NONE;
						end
						default: begin
							emit_kind = KIND_TICK;
							emit_slot = '0;
							emit_mode = MODE_DONE;
						end
					endcase
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
					if (!held_vld_q) begin
						// nothing fired: one empty service result
						emit_slot  = '0;
						emit_mode  = MODE_DONE;
						emit_fired = 1'b0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// latch the item
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= act_t'(action);
			slot_q    <= slot;
			rewrite_q <= rewrite;
			cnt_q     <= COUNT_BITS'(load_count);
			per_q     <= COUNT_BITS'(reload_period);
			smode_q   <= (start_mode == MODE_NONE) ? MODE_DONE : mode_t'(start_mode);
		end
	end

	// slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				reg_q[i]  <= 1'b0;
				mode_q[i] <= MODE_DONE;
			end
		end else begin
			if (mode_we) begin
				mode_q[mode_wa] <= mode_wd;
			end
			if (reg_set) begin
				reg_q[mode_wa] <= 1'b1;
			end
		end
	end

	// sweep counter and held fire event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			p_vld_s1   <= 1'b0;
			held_vld_q <= 1'b0;
			fire_cnt_q <= '0;
		end else begin
			if (accept) begin
				idx_q      <= '0;
				p_vld_s1   <= 1'b0;
				held_vld_q <= 1'b0;
				fire_cnt_q <= '0;
			end else if (state_q == ST_SWEEP && advance) begin
				if (idx_q != IDX_W'(NUM_SLOTS)) begin
					idx_q    <= idx_q + IDX_W'(1);
					p_vld_s1 <= 1'b1;
				end else begin
					p_vld_s1 <= 1'b0;
				end
				if (fire_rec) begin
					held_vld_q <= 1'b1;
					fire_cnt_q <= fire_cnt_q + FIRE_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SWEEP && advance && idx_q != IDX_W'(NUM_SLOTS)) begin
			p_idx_s1 <= idx_q[AW-1:0];
		end
		if (fire_rec) begin
			held_slot_q <= SLOT_W'(p_idx_s1);
			held_mode_q <= fire_mode;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q  <= emit_kind;
			out_slot_q  <= emit_slot;
			out_mode_q  <= emit_mode;
			out_fired_q <= emit_fired;
			out_last_q  <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign reply_kind = out_kind_q;
	assign reply_slot = out_slot_q;
	assign slot_mode  = out_mode_q;
	assign fired      = out_fired_q;
	assign last       = out_last_q;

endmodule

// File: design/msb_count_ram.sv
// ----------------------------------------------------------------------------
// msb_count_ram - count and period store
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module msb_count_ram #(
	parameter int DEPTH = 16,
	parameter int DW    = 64
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [DW-1:0]                         wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [DW-1:0]                         rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/msb_dec_unit.sv
// ----------------------------------------------------------------------------
// msb_dec_unit - shared zero test and decrement
// Tests one count for zero and forms the count less one.
// ----------------------------------------------------------------------------
module msb_dec_unit #(
	parameter int WIDTH = 32
) (
	input  logic [WIDTH-1:0] operand,
	output logic             is_zero,
	output logic [WIDTH-1:0] dec
);

	assign is_zero = (operand == '0);
	assign dec     = operand - WIDTH'(1);

endmodule
